// ===== design/l2p_pkg.sv =====
// ----------------------------------------------------------------------------
// l2p_pkg
// Constants shared by the l2/l3/l4 header parser: widths, ethertypes, protocol
// numbers, ip versions, header offsets, minimum lengths and status codes.
// ----------------------------------------------------------------------------
package l2p_pkg;

  localparam int unsigned COUNT_W = 17;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd131071;

  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86dd;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [3:0] IP_VER_4 = 4'd4;
  localparam logic [3:0] IP_VER_6 = 4'd6;

  localparam logic [4:0] L3_PLAIN = 5'd14;
  localparam logic [4:0] L3_TAGGED = 5'd18;

  localparam logic [6:0] IPV4_MIN_HDR = 7'd20;
  localparam logic [6:0] IPV6_HDR = 7'd40;
  localparam logic [15:0] TCP_MIN_LEN = 16'd20;
  localparam logic [15:0] UDP_MIN_LEN = 16'd8;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

// ===== design/l2_l3_l4_header_parser.sv =====
// ----------------------------------------------------------------------------
// l2_l3_l4_header_parser
// Streaming Ethernet / 802.1Q / IPv4 / IPv6 / TCP / UDP header parser that
// reports one summary per frame.
// ----------------------------------------------------------------------------
// Frame bytes enter one per cycle in wire order, starting at the destination
// MAC, with last_byte set on the final byte. Each request updates a saturating
// byte counter and a handful of capture registers; on the last byte the checks
// against the frame length run in the same cycle and the summary lands in the
// result register, visible on the next cycle, while the next frame's first
// byte may already be taken. Sustained rate is one byte per cycle. The only
// back-pressure comes from the single result register: a last byte is held
// off while a result waits and result_stall is high, other bytes keep flowing.
// IPv6 extension headers and a second VLAN tag are not walked.
// ----------------------------------------------------------------------------
module l2_l3_l4_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        status,
  output logic [15:0] frame_type,
  output logic        has_vlan,
  output logic [4:0]  net_offset,
  output logic [2:0]  ip_ver,
  output logic [7:0]  protocol,
  output logic [6:0]  xport_offset,
  output logic [15:0] source_port,
  output logic [15:0] dest_port
);

  logic [l2p_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0] type_word, type_word_next;
  logic        vlan_seen, vlan_seen_next;
  logic [4:0]  net_start, net_start_next;
  logic [3:0]  version_field, version_field_next;
  logic [6:0]  header_bytes, header_bytes_next;
  logic [15:0] ip_length_field, ip_length_field_next;
  logic [7:0]  proto_capture, proto_capture_next;
  logic [15:0] source_port_capture, source_port_capture_next;
  logic [15:0] dest_port_capture, dest_port_capture_next;

  logic        status_next;
  logic [15:0] frame_type_next;
  logic        has_vlan_next;
  logic [4:0]  net_offset_next;
  logic [2:0]  ip_ver_next;
  logic [7:0]  protocol_next;
  logic [6:0]  xport_offset_next;
  logic [15:0] source_port_next;
  logic [15:0] dest_port_next;

  logic accept;
  logic finish;

  // only a last byte needs the result register
  assign byte_stall = result_valid & result_stall & last_byte;
  assign accept     = byte_valid & ~byte_stall;
  assign finish     = accept & last_byte;

  // capture path followed by the end-of-frame checks
  always_comb begin
    logic [l2p_pkg::COUNT_W-1:0] pos;
    logic [l2p_pkg::COUNT_W-1:0] flen;
    logic [l2p_pkg::COUNT_W-1:0] rel;
    logic [l2p_pkg::COUNT_W-1:0] k;
    logic [15:0] tw;
    logic        vs;
    logic [4:0]  ns;
    logic [3:0]  ver;
    logic [6:0]  hb;
    logic [15:0] iplen;
    logic [7:0]  proto;
    logic [15:0] sp;
    logic [15:0] dp;
    logic        in_ip;
    logic        is_ip;
    logic        ip_ok;
    logic [15:0] l4_len;
    logic [17:0] ip_end;

    pos   = byte_count;
    tw    = type_word;
    vs    = vlan_seen;
    ns    = net_start;
    ver   = version_field;
    hb    = header_bytes;
    iplen = ip_length_field;
    proto = proto_capture;
    sp    = source_port_capture;
    dp    = dest_port_capture;
    rel   = '0;
    k     = '0;
    in_ip = 1'b0;
    is_ip = 1'b0;
    ip_ok = 1'b0;
    l4_len = '0;
    ip_end = '0;

    flen = (byte_count < l2p_pkg::COUNT_MAX) ? byte_count + 17'd1 : byte_count;

    // ethertype and optional tag
    if (pos == 17'd12) begin
      tw = {data_byte, 8'h00};
    end else if (pos == 17'd13) begin
      tw = {tw[15:8], data_byte};
      ns = (tw == l2p_pkg::TYPE_VLAN) ? l2p_pkg::L3_TAGGED : l2p_pkg::L3_PLAIN;
    end else if (pos == 17'd16 && ns == l2p_pkg::L3_TAGGED) begin
      tw = {data_byte, 8'h00};
    end else if (pos == 17'd17 && ns == l2p_pkg::L3_TAGGED) begin
      tw = {tw[15:8], data_byte};
      vs = 1'b1;
    end

    if (ns != 5'd0 && pos >= {12'd0, ns} && !(ns == l2p_pkg::L3_TAGGED && !vs)) begin
      rel = pos - {12'd0, ns};
      if (tw == l2p_pkg::TYPE_IPV4) begin
        in_ip = 1'b1;
        if (rel == 17'd0) begin
          ver = data_byte[7:4];
          hb  = {1'b0, data_byte[3:0], 2'b00};
        end else if (rel == 17'd2) begin
          iplen = {data_byte, 8'h00};
        end else if (rel == 17'd3) begin
          iplen = {iplen[15:8], data_byte};
        end else if (rel == 17'd9) begin
          proto = data_byte;
        end
      end else if (tw == l2p_pkg::TYPE_IPV6) begin
        in_ip = 1'b1;
        if (rel == 17'd0) begin
          ver = data_byte[7:4];
          hb  = l2p_pkg::IPV6_HDR;
        end else if (rel == 17'd4) begin
          iplen = {data_byte, 8'h00};
        end else if (rel == 17'd5) begin
          iplen = {iplen[15:8], data_byte};
        end else if (rel == 17'd6) begin
          proto = data_byte;
        end
      end
      // transport ports sit right after the ip header
      if (in_ip && hb >= l2p_pkg::IPV4_MIN_HDR && rel >= {10'd0, hb}) begin
        k = rel - {10'd0, hb};
        case (k)
          17'd0:   sp = {data_byte, 8'h00};
          17'd1:   sp = {sp[15:8], data_byte};
          17'd2:   dp = {data_byte, 8'h00};
          17'd3:   dp = {dp[15:8], data_byte};
          default: ;
        endcase
      end
    end

    // end-of-frame summary
    status_next       = l2p_pkg::STATUS_ERR;
    frame_type_next   = '0;
    has_vlan_next     = 1'b0;
    net_offset_next   = '0;
    ip_ver_next       = '0;
    protocol_next     = '0;
    xport_offset_next = '0;
    source_port_next  = '0;
    dest_port_next    = '0;

    if (flen < 17'd14) begin
      status_next = l2p_pkg::STATUS_ERR;
    end else if (ns == l2p_pkg::L3_TAGGED && !vs) begin
      frame_type_next = l2p_pkg::TYPE_VLAN;
    end else begin
      frame_type_next = tw;
      has_vlan_next   = vs;
      net_offset_next = ns;
      if (tw == l2p_pkg::TYPE_IPV4) begin
        is_ip  = 1'b1;
        ip_end = {13'd0, ns} + {2'd0, iplen};
        ip_ok  = !(flen < {12'd0, ns} + 17'd20) && ver == l2p_pkg::IP_VER_4 &&
                 hb >= l2p_pkg::IPV4_MIN_HDR && iplen >= {9'd0, hb} &&
                 ip_end <= {1'b0, flen};
        l4_len = iplen - {9'd0, hb};
      end else if (tw == l2p_pkg::TYPE_IPV6) begin
        is_ip  = 1'b1;
        ip_end = {13'd0, ns} + 18'd40 + {2'd0, iplen};
        ip_ok  = !(flen < {12'd0, ns} + 17'd40) && ver == l2p_pkg::IP_VER_6 &&
                 ip_end <= {1'b0, flen};
        l4_len = iplen;
      end

      if (!is_ip) begin
        status_next = l2p_pkg::STATUS_OK;
      end else if (ip_ok) begin
        ip_ver_next       = ver[2:0];
        protocol_next     = proto;
        xport_offset_next = {2'd0, ns} + hb;
        if (proto == l2p_pkg::PROTO_TCP || proto == l2p_pkg::PROTO_UDP) begin
          if (l4_len >= ((proto == l2p_pkg::PROTO_TCP) ? l2p_pkg::TCP_MIN_LEN
                                                       : l2p_pkg::UDP_MIN_LEN)) begin
            source_port_next = sp;
            dest_port_next   = dp;
            status_next      = l2p_pkg::STATUS_OK;
          end
        end else begin
          status_next = l2p_pkg::STATUS_OK;
        end
      end
    end

    // state is cleared after the last byte of each frame
    if (last_byte) begin
      byte_count_next          = '0;
      type_word_next           = '0;
      vlan_seen_next           = 1'b0;
      net_start_next           = '0;
      version_field_next       = '0;
      header_bytes_next        = '0;
      ip_length_field_next     = '0;
      proto_capture_next       = '0;
      source_port_capture_next = '0;
      dest_port_capture_next   = '0;
    end else begin
      byte_count_next          = flen;
      type_word_next           = tw;
      vlan_seen_next           = vs;
      net_start_next           = ns;
      version_field_next       = ver;
      header_bytes_next        = hb;
      ip_length_field_next     = iplen;
      proto_capture_next       = proto;
      source_port_capture_next = sp;
      dest_port_capture_next   = dp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count          <= '0;
      type_word           <= '0;
      vlan_seen           <= 1'b0;
      net_start           <= '0;
      version_field       <= '0;
      header_bytes        <= '0;
      ip_length_field     <= '0;
      proto_capture       <= '0;
      source_port_capture <= '0;
      dest_port_capture   <= '0;
    end else if (accept) begin
      byte_count          <= byte_count_next;
      type_word           <= type_word_next;
      vlan_seen           <= vlan_seen_next;
      net_start           <= net_start_next;
      version_field       <= version_field_next;
      header_bytes        <= header_bytes_next;
      ip_length_field     <= ip_length_field_next;
      proto_capture       <= proto_capture_next;
      source_port_capture <= source_port_capture_next;
      dest_port_capture   <= dest_port_capture_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status       <= status_next;
      frame_type   <= frame_type_next;
      has_vlan     <= has_vlan_next;
      net_offset   <= net_offset_next;
      ip_ver       <= ip_ver_next;
      protocol     <= protocol_next;
      xport_offset <= xport_offset_next;
      source_port  <= source_port_next;
      dest_port    <= dest_port_next;
    end
  end

  // frame state starts over after the last byte
  assert property (@(posedge clk) disable iff (rst)
    finish |=> byte_count == '0 && net_start == '0 && type_word == '0)
    else $error("frame state not cleared after last byte");

  // a result is offered in the cycle after its last byte
  assert property (@(posedge clk) disable iff (rst)
    finish |=> result_valid)
    else $error("result missing after last byte");

  // ip fields only appear with a reached network header
  assert property (@(posedge clk) disable iff (rst)
    result_valid && ip_ver != 3'd0 |->
      net_offset == l2p_pkg::L3_PLAIN || net_offset == l2p_pkg::L3_TAGGED)
    else $error("ip version reported without network header");

  // a skipped tag always moves the network header
  assert property (@(posedge clk) disable iff (rst)
    result_valid && has_vlan |-> net_offset == l2p_pkg::L3_TAGGED)
    else $error("vlan flag with wrong network offset");

  // failed ip checks leave the later fields empty
  assert property (@(posedge clk) disable iff (rst)
    result_valid && ip_ver == 3'd0 |->
      protocol == 8'd0 && xport_offset == 7'd0 && source_port == 16'd0 &&
      dest_port == 16'd0)
    else $error("transport fields set without ip header");

endmodule
